FILE: design/lkw_pkg.sv
// Shared types, constants and helper functions of the weighted Lucas-Kanade window block.
package lkw_pkg;

	localparam int PIX_W        = 8;
	localparam int PIX_WEIGHT_W = 16;
	localparam int DIFF_W       = 9;
	localparam int PAIR_W       = 17;
	localparam int SUM_W        = 42;
	localparam int ACC_W        = 86;
	localparam int MAG_W        = 85;
	localparam int MC_W         = 64;
	localparam int ML_W         = 42;
	localparam int PRD_W        = MC_W + ML_W;
	localparam int VEL_W        = 16;
	localparam int STATUS_W     = 2;
	localparam int DET_THR_W    = 40;
	localparam int SPD_THR_W    = 16;
	localparam int APB_ADDR_W   = 4;
	localparam int APB_DATA_W   = 64;

	localparam int WEIGHT_BITS_DEF = 16;

	localparam logic [DET_THR_W-1:0] DET_THR_RST = 40'd1;
	localparam logic [SPD_THR_W-1:0] SPD_THR_RST = 16'd26;

	// Register select taken from address bit 3 (registers at 0 and 8)
	localparam logic REG_DET_THR = 1'b0;
	localparam logic REG_SPD_THR = 1'b1;

	localparam logic [STATUS_W-1:0] ST_MOVING   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_SLOW     = 2'd1;
	localparam logic [STATUS_W-1:0] ST_SINGULAR = 2'd2;

	localparam logic [14:0] UNIT_ONE = 15'd16384;

	typedef struct packed {
		logic [PIX_W-1:0]        pix_right;
		logic [PIX_W-1:0]        pix_left;
		logic [PIX_W-1:0]        pix_down;
		logic [PIX_W-1:0]        pix_up;
		logic [PIX_W-1:0]        pix_now;
		logic [PIX_W-1:0]        pix_before;
		logic [PIX_WEIGHT_W-1:0] weight;
		logic                    last;
	} pix_t;

	typedef struct packed {
		logic signed [VEL_W-1:0] vel_x;
		logic signed [VEL_W-1:0] vel_y;
		logic [STATUS_W-1:0]     status;
	} res_t;

	typedef struct packed {
		logic [DET_THR_W-1:0] det_threshold;
		logic [SPD_THR_W-1:0] speed_threshold;
	} cfg_t;

	typedef struct packed {
		logic signed [SUM_W-1:0] xx;
		logic signed [SUM_W-1:0] yy;
		logic signed [SUM_W-1:0] xy;
		logic signed [SUM_W-1:0] xt;
		logic signed [SUM_W-1:0] yt;
	} sums_t;

	function automatic logic [SUM_W-1:0] mag_sum(input logic signed [SUM_W-1:0] v);
		return v[SUM_W-1] ? SUM_W'(-v) : SUM_W'(v);
	endfunction

	function automatic logic [MAG_W-1:0] mag_acc(input logic signed [ACC_W-1:0] v);
		return v[ACC_W-1] ? MAG_W'(-v) : MAG_W'(v);
	endfunction

endpackage

FILE: design/lkw_mul.sv
// Shared shift-add multiplier: one partial product per cycle, fixed step count.
module lkw_mul (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [lkw_pkg::MC_W-1:0]    mcand,
	input  logic [lkw_pkg::ML_W-1:0]    mult,
	output logic                        done,
	output logic [lkw_pkg::PRD_W-1:0]   prod
);

	localparam int CNT_W = $clog2(lkw_pkg::ML_W + 1);

	logic [CNT_W-1:0]           cnt_q;
	logic                       done_q;
	logic [lkw_pkg::MC_W-1:0]   mcand_q;
	logic [lkw_pkg::MC_W-1:0]   hi_q;
	logic [lkw_pkg::ML_W-1:0]   lo_q;
	logic [lkw_pkg::MC_W:0]     sum_c;

	assign sum_c = {1'b0, hi_q} + (lo_q[0] ? {1'b0, mcand_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNT_W'(lkw_pkg::ML_W);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - 1'b1;
			done_q <= (cnt_q == CNT_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q <= mcand;
			hi_q    <= '0;
			lo_q    <= mult;
		end else if (cnt_q != '0) begin
			hi_q <= sum_c[lkw_pkg::MC_W:1];
			lo_q <= {sum_c[0], lo_q[lkw_pkg::ML_W-1:1]};
		end
	end

	assign done = done_q;
	assign prod = {hi_q, lo_q};

endmodule

FILE: design/lkw_solve.sv
// Window solver: Cramer's rule, threshold tests, square root and unit direction.
module lkw_solve (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  lkw_pkg::sums_t   sums,
	input  lkw_pkg::cfg_t    cfg,
	output logic             idle,
	output logic             res_valid,
	input  logic             res_ready,
	output lkw_pkg::res_t    res
);

	localparam int SQ_W     = 64;
	localparam int NUM_W    = 45;
	localparam int ROOT_W   = 31;
	localparam int REM_W    = ROOT_W + 1;
	localparam int DCNT_W   = $clog2(NUM_W + 1);
	localparam int PA_W     = 63;
	localparam int PD_W     = 62;
	localparam int ST2_W    = 32;
	localparam int RHS_W    = 94;
	localparam logic [SQ_W-1:0] ROOT_BIT0 = 64'h4000_0000_0000_0000;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_MUL  = 4'd1;
	localparam logic [3:0] S_MWT  = 4'd2;
	localparam logic [3:0] S_THR  = 4'd3;
	localparam logic [3:0] S_SHA  = 4'd4;
	localparam logic [3:0] S_CMP  = 4'd5;
	localparam logic [3:0] S_SHB  = 4'd6;
	localparam logic [3:0] S_ROOT = 4'd7;
	localparam logic [3:0] S_DIV  = 4'd8;
	localparam logic [3:0] S_DONE = 4'd9;

	localparam logic [3:0] OP_YYXX = 4'd0;
	localparam logic [3:0] OP_XYXY = 4'd1;
	localparam logic [3:0] OP_YTXX = 4'd2;
	localparam logic [3:0] OP_XYXT = 4'd3;
	localparam logic [3:0] OP_YYXT = 4'd4;
	localparam logic [3:0] OP_XYYT = 4'd5;
	localparam logic [3:0] OP_A0SQ = 4'd6;
	localparam logic [3:0] OP_A1SQ = 4'd7;
	localparam logic [3:0] OP_STSQ = 4'd8;
	localparam logic [3:0] OP_A2SQ = 4'd9;
	localparam logic [3:0] OP_RHS  = 4'd10;
	localparam logic [3:0] OP_B0SQ = 4'd11;
	localparam logic [3:0] OP_B1SQ = 4'd12;

	logic [3:0] state_q;
	logic [3:0] op_q;

	lkw_pkg::sums_t sums_q;
	logic signed [lkw_pkg::ACC_W-1:0] acc_q, det_q, nv_q, nh_q;
	logic [lkw_pkg::MAG_W-1:0] sv_q, sh_q, sd_q;
	logic [PA_W-1:0]   pa_q;
	logic [PD_W-1:0]   pd_q;
	logic [ST2_W-1:0]  st2_q;
	logic [RHS_W-1:0]  rhs_q;
	logic [SQ_W-1:0]   sqv_q, sqr_q, sqb_q;
	logic [ROOT_W-1:0] m_q;
	logic [NUM_W-1:0]  num_q;
	logic [REM_W-1:0]  rem_q;
	logic [DCNT_W-1:0] dcnt_q;
	logic              dsel_q;
	lkw_pkg::res_t     res_q;

	// shared multiplier hookup
	logic                          mul_start;
	logic [lkw_pkg::MC_W-1:0]      mul_a;
	logic [lkw_pkg::ML_W-1:0]      mul_b;
	logic                          mul_sg;
	logic                          mul_done;
	logic [lkw_pkg::PRD_W-1:0]     mul_p;
	logic signed [lkw_pkg::ACC_W-1:0] pv_c, sp_c;

	logic [lkw_pkg::MAG_W-1:0] ad_c;
	logic [SQ_W-1:0]   root_t_c;
	logic [REM_W-1:0]  rsh_c;
	logic              qbit_c;
	logic [14:0]       mag_c;
	logic              neg_c;
	logic signed [lkw_pkg::VEL_W-1:0] vel_c;
	logic [PD_W-1:0]   sq_c;

	lkw_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.mcand  (mul_a),
		.mult   (mul_b),
		.done   (mul_done),
		.prod   (mul_p)
	);

	assign mul_start = (state_q == S_MUL);

	always_comb begin
		mul_a  = '0;
		mul_b  = '0;
		mul_sg = 1'b0;
		case (op_q)
			OP_YYXX: begin
				mul_a  = lkw_pkg::MC_W'(lkw_pkg::mag_sum(sums_q.yy));
				mul_b  = lkw_pkg::mag_sum(sums_q.xx);
				mul_sg = sums_q.yy[lkw_pkg::SUM_W-1] ^ sums_q.xx[lkw_pkg::SUM_W-1];
			end
			OP_XYXY: begin
				mul_a  = lkw_pkg::MC_W'(lkw_pkg::mag_sum(sums_q.xy));
				mul_b  = lkw_pkg::mag_sum(sums_q.xy);
			end
			OP_YTXX: begin
				mul_a  = lkw_pkg::MC_W'(lkw_pkg::mag_sum(sums_q.yt));
				mul_b  = lkw_pkg::mag_sum(sums_q.xx);
				mul_sg = sums_q.yt[lkw_pkg::SUM_W-1] ^ sums_q.xx[lkw_pkg::SUM_W-1];
			end
			OP_XYXT: begin
				mul_a  = lkw_pkg::MC_W'(lkw_pkg::mag_sum(sums_q.xy));
				mul_b  = lkw_pkg::mag_sum(sums_q.xt);
				mul_sg = sums_q.xy[lkw_pkg::SUM_W-1] ^ sums_q.xt[lkw_pkg::SUM_W-1];
			end
			OP_YYXT: begin
				mul_a  = lkw_pkg::MC_W'(lkw_pkg::mag_sum(sums_q.yy));
				mul_b  = lkw_pkg::mag_sum(sums_q.xt);
				mul_sg = sums_q.yy[lkw_pkg::SUM_W-1] ^ sums_q.xt[lkw_pkg::SUM_W-1];
			end
			OP_XYYT: begin
				mul_a  = lkw_pkg::MC_W'(lkw_pkg::mag_sum(sums_q.xy));
				mul_b  = lkw_pkg::mag_sum(sums_q.yt);
				mul_sg = sums_q.xy[lkw_pkg::SUM_W-1] ^ sums_q.yt[lkw_pkg::SUM_W-1];
			end
			OP_A0SQ: begin
				mul_a = lkw_pkg::MC_W'(sv_q[ROOT_W-1:0]);
				mul_b = lkw_pkg::ML_W'(sv_q[ROOT_W-1:0]);
			end
			OP_A1SQ: begin
				mul_a = lkw_pkg::MC_W'(sh_q[ROOT_W-1:0]);
				mul_b = lkw_pkg::ML_W'(sh_q[ROOT_W-1:0]);
			end
			OP_STSQ: begin
				mul_a = lkw_pkg::MC_W'(cfg.speed_threshold);
				mul_b = lkw_pkg::ML_W'(cfg.speed_threshold);
			end
			OP_A2SQ: begin
				mul_a = lkw_pkg::MC_W'(sd_q[ROOT_W-1:0]);
				mul_b = lkw_pkg::ML_W'(sd_q[ROOT_W-1:0]);
			end
			OP_RHS: begin
				mul_a = lkw_pkg::MC_W'(pd_q);
				mul_b = lkw_pkg::ML_W'(st2_q);
			end
			OP_B0SQ: begin
				mul_a = lkw_pkg::MC_W'(sv_q[ROOT_W-2:0]);
				mul_b = lkw_pkg::ML_W'(sv_q[ROOT_W-2:0]);
			end
			OP_B1SQ: begin
				mul_a = lkw_pkg::MC_W'(sh_q[ROOT_W-2:0]);
				mul_b = lkw_pkg::ML_W'(sh_q[ROOT_W-2:0]);
			end
			default: begin
				mul_a = '0;
			end
		endcase
	end

	assign pv_c = $signed(lkw_pkg::ACC_W'(mul_p[2*lkw_pkg::SUM_W-1:0]));
	assign sp_c = mul_sg ? -pv_c : pv_c;
	assign sq_c = mul_p[PD_W-1:0];
	assign ad_c = lkw_pkg::mag_acc(det_q);

	assign root_t_c = sqr_q + sqb_q;
	assign rsh_c    = {rem_q[REM_W-2:0], num_q[NUM_W-1]};
	assign qbit_c   = (rsh_c >= {1'b0, m_q});

	// clamp the quotient and apply the direction of -flow
	always_comb begin
		mag_c = (num_q > NUM_W'(lkw_pkg::UNIT_ONE)) ? lkw_pkg::UNIT_ONE : num_q[14:0];
		if (!dsel_q) begin
			neg_c = (nh_q[lkw_pkg::ACC_W-1] == det_q[lkw_pkg::ACC_W-1]);
		end else begin
			neg_c = (nv_q[lkw_pkg::ACC_W-1] == det_q[lkw_pkg::ACC_W-1]);
		end
		vel_c = neg_c ? -$signed({1'b0, mag_c}) : $signed({1'b0, mag_c});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= OP_YYXX;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q    <= OP_YYXX;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					state_q <= S_MWT;
				end
				S_MWT: begin
					if (mul_done) begin
						case (op_q)
							OP_XYYT: state_q <= S_THR;
							OP_RHS:  state_q <= S_CMP;
							OP_B1SQ: state_q <= S_ROOT;
							default: begin
								op_q    <= op_q + 1'b1;
								state_q <= S_MUL;
							end
						endcase
					end
				end
				S_THR: begin
					state_q <= (ad_c > lkw_pkg::MAG_W'(cfg.det_threshold)) ? S_SHA : S_DONE;
				end
				S_SHA: begin
					if (((sv_q | sh_q | sd_q) >> ROOT_W) == '0) begin
						op_q    <= OP_A0SQ;
						state_q <= S_MUL;
					end
				end
				S_CMP: begin
					if (pa_q != '0 && RHS_W'({pa_q, 16'd0}) > rhs_q) begin
						state_q <= S_SHB;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_SHB: begin
					if (((sv_q | sh_q) >> (ROOT_W - 1)) == '0) begin
						op_q    <= OP_B0SQ;
						state_q <= S_MUL;
					end
				end
				S_ROOT: begin
					if (sqb_q == '0) begin
						state_q <= (sqr_q == '0) ? S_DONE : S_DIV;
					end
				end
				S_DIV: begin
					if (dcnt_q == '0 && dsel_q) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				sums_q <= sums;
			end
			S_MWT: begin
				if (mul_done) begin
					case (op_q)
						OP_YYXX, OP_YTXX, OP_YYXT: acc_q <= sp_c;
						OP_XYXY: det_q <= acc_q - sp_c;
						OP_XYXT: nv_q  <= acc_q - sp_c;
						OP_XYYT: nh_q  <= acc_q - sp_c;
						OP_A0SQ, OP_B0SQ: pa_q <= PA_W'(sq_c);
						OP_A1SQ: pa_q  <= pa_q + PA_W'(sq_c);
						OP_STSQ: st2_q <= mul_p[ST2_W-1:0];
						OP_A2SQ: pd_q  <= sq_c;
						OP_RHS:  rhs_q <= mul_p[RHS_W-1:0];
						OP_B1SQ: begin
							sqv_q <= SQ_W'(pa_q) + SQ_W'(sq_c);
							sqr_q <= '0;
							sqb_q <= ROOT_BIT0;
						end
						default: begin
							acc_q <= acc_q;
						end
					endcase
				end
			end
			S_THR: begin
				sv_q  <= lkw_pkg::mag_acc(nv_q);
				sh_q  <= lkw_pkg::mag_acc(nh_q);
				sd_q  <= ad_c;
				res_q <= '{vel_x: '0, vel_y: '0, status: lkw_pkg::ST_SINGULAR};
			end
			S_SHA: begin
				if (((sv_q | sh_q | sd_q) >> ROOT_W) != '0) begin
					sv_q <= sv_q >> 1;
					sh_q <= sh_q >> 1;
					sd_q <= sd_q >> 1;
				end
			end
			S_CMP: begin
				sv_q  <= lkw_pkg::mag_acc(nv_q);
				sh_q  <= lkw_pkg::mag_acc(nh_q);
				res_q <= '{vel_x: '0, vel_y: '0, status: lkw_pkg::ST_SLOW};
			end
			S_SHB: begin
				if (((sv_q | sh_q) >> (ROOT_W - 1)) != '0) begin
					sv_q <= sv_q >> 1;
					sh_q <= sh_q >> 1;
				end
			end
			S_ROOT: begin
				if (sqb_q != '0) begin
					if (sqv_q >= root_t_c) begin
						sqv_q <= sqv_q - root_t_c;
						sqr_q <= (sqr_q >> 1) + sqb_q;
					end else begin
						sqr_q <= sqr_q >> 1;
					end
					sqb_q <= sqb_q >> 2;
				end else begin
					// horizontal part first
					m_q    <= sqr_q[ROOT_W-1:0];
					num_q  <= NUM_W'({sh_q[ROOT_W-2:0], 14'd0}) + NUM_W'(sqr_q[ROOT_W-1:1]);
					rem_q  <= '0;
					dcnt_q <= DCNT_W'(NUM_W);
					dsel_q <= 1'b0;
				end
			end
			S_DIV: begin
				if (dcnt_q != '0) begin
					rem_q  <= qbit_c ? (rsh_c - {1'b0, m_q}) : rsh_c;
					num_q  <= {num_q[NUM_W-2:0], qbit_c};
					dcnt_q <= dcnt_q - 1'b1;
				end else if (!dsel_q) begin
					res_q.vel_x <= vel_c;
					num_q  <= NUM_W'({sv_q[ROOT_W-2:0], 14'd0}) + NUM_W'(m_q[ROOT_W-1:1]);
					rem_q  <= '0;
					dcnt_q <= DCNT_W'(NUM_W);
					dsel_q <= 1'b1;
				end else begin
					res_q.vel_y  <= vel_c;
					res_q.status <= lkw_pkg::ST_MOVING;
				end
			end
			default: begin
				res_q <= res_q;
			end
		endcase
	end

	assign idle      = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res       = res_q;

endmodule

FILE: design/lkw_regs.sv
// APB configuration registers: determinant and speed thresholds.
module lkw_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [lkw_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [lkw_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [lkw_pkg::APB_DATA_W-1:0]   prdata,
	output logic                             pready,
	output lkw_pkg::cfg_t                    cfg
);

	lkw_pkg::cfg_t cfg_q;
	logic          wr_c;
	logic          sel_c;

	assign pready = 1'b1;
	assign wr_c   = psel && penable && pwrite;
	assign sel_c  = paddr[3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.det_threshold   <= lkw_pkg::DET_THR_RST;
			cfg_q.speed_threshold <= lkw_pkg::SPD_THR_RST;
		end else if (wr_c) begin
			case (sel_c)
				lkw_pkg::REG_DET_THR: cfg_q.det_threshold <=
					pwdata[lkw_pkg::DET_THR_W-1:0];
				lkw_pkg::REG_SPD_THR: cfg_q.speed_threshold <=
					pwdata[lkw_pkg::SPD_THR_W-1:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	always_comb begin
		case (sel_c)
			lkw_pkg::REG_DET_THR: prdata = lkw_pkg::APB_DATA_W'(cfg_q.det_threshold);
			lkw_pkg::REG_SPD_THR: prdata = lkw_pkg::APB_DATA_W'(cfg_q.speed_threshold);
			default:              prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

FILE: design/weighted_lucas_kanade_window.sv
// Top level: pixel accumulation of the weighted normal system and window solve.
//
// Pixels arrive on the pix channel (valid/ready), one window position per
// transaction; the transaction with last set closes the window. Each pixel
// runs five difference products one per cycle through a 9 x 9 multiplier
// and a 17 x WEIGHT_BITS weight multiplier, which then drain through the
// pp_s1 and term_s2 registers; pix_ready is low from each acceptance until
// the last product has been added. After the last pixel the sums pass to
// the solver and clear, which holds pix_ready low until the solver takes
// them; the next window accumulates while the solver runs. The solver
// reuses one serial 64 x 42 multiplier: six products for the system, then
// five for the speed test, two more plus a 32-step root and two 45-step
// divisions for the direction. If a window closes while the solver is
// still busy, pix_ready stays low until it is free. One result per window
// leaves on the res channel and holds until res_ready; the solver stays
// busy while it waits. Reset clears the sums, drops any result in flight
// and loads the threshold registers with their defaults.
module weighted_lucas_kanade_window #(
	parameter int WEIGHT_BITS = lkw_pkg::WEIGHT_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             pix_valid,
	output logic                             pix_ready,
	input  lkw_pkg::pix_t                    pix,
	output logic                             res_valid,
	input  logic                             res_ready,
	output lkw_pkg::res_t                    res,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [lkw_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [lkw_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [lkw_pkg::APB_DATA_W-1:0]   prdata,
	output logic                             pready
);

	localparam int WSH = lkw_pkg::PIX_WEIGHT_W - WEIGHT_BITS;

	localparam logic [2:0] PRD_XX = 3'd0;
	localparam logic [2:0] PRD_YY = 3'd1;
	localparam logic [2:0] PRD_XY = 3'd2;
	localparam logic [2:0] PRD_XT = 3'd3;
	localparam logic [2:0] PRD_YT = 3'd4;
	localparam logic [2:0] CNT_END = 3'd6;

	logic                               busy_q;
	logic                               pend_q;
	logic                               last_q;
	logic [2:0]                         cnt_q;
	logic signed [lkw_pkg::DIFF_W-1:0]  dx_q, dy_q, dt_q;
	logic [WEIGHT_BITS-1:0]             w_q;
	logic signed [lkw_pkg::PAIR_W-1:0]  pp_s1;
	logic signed [lkw_pkg::SUM_W-1:0]   term_s2;
	lkw_pkg::sums_t                     sum_q;

	logic signed [lkw_pkg::DIFF_W-1:0]  d1_c, d2_c;
	logic signed [lkw_pkg::PAIR_W-1:0]  pp_c;
	logic signed [WEIGHT_BITS+17:0]     pw_c;
	logic [2:0]                         add_sel_c;
	logic                               pix_acc;
	logic                               slv_start;
	logic                               slv_idle;
	lkw_pkg::cfg_t                      cfg;

	lkw_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	lkw_solve u_solve (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (slv_start),
		.sums      (sum_q),
		.cfg       (cfg),
		.idle      (slv_idle),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	assign pix_ready = !busy_q && !pend_q;
	assign pix_acc   = pix_valid && pix_ready;
	assign slv_start = pend_q && slv_idle;

	always_comb begin
		case (cnt_q)
			PRD_XX: begin d1_c = dx_q; d2_c = dx_q; end
			PRD_YY: begin d1_c = dy_q; d2_c = dy_q; end
			PRD_XY: begin d1_c = dx_q; d2_c = dy_q; end
			PRD_XT: begin d1_c = dx_q; d2_c = dt_q; end
			PRD_YT: begin d1_c = dy_q; d2_c = dt_q; end
			default: begin d1_c = dx_q; d2_c = dx_q; end
		endcase
	end

	assign pp_c      = d1_c * d2_c;
	assign pw_c      = pp_s1 * $signed({1'b0, w_q});
	assign add_sel_c = cnt_q - 3'd2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pend_q <= 1'b0;
			cnt_q  <= '0;
			sum_q  <= '0;
		end else begin
			if (pix_acc) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_END) begin
					busy_q <= 1'b0;
					pend_q <= last_q;
				end
			end
			// products land after passing the pp_s1 and term_s2 registers
			if (busy_q && cnt_q >= 3'd2) begin
				case (add_sel_c)
					PRD_XX: sum_q.xx <= sum_q.xx + term_s2;
					PRD_YY: sum_q.yy <= sum_q.yy + term_s2;
					PRD_XY: sum_q.xy <= sum_q.xy + term_s2;
					PRD_XT: sum_q.xt <= sum_q.xt + term_s2;
					PRD_YT: sum_q.yt <= sum_q.yt + term_s2;
					default: sum_q <= sum_q;
				endcase
			end
			if (slv_start) begin
				sum_q  <= '0;
				pend_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pix_acc) begin
			dx_q   <= $signed({1'b0, pix.pix_right}) - $signed({1'b0, pix.pix_left});
			dy_q   <= $signed({1'b0, pix.pix_down}) - $signed({1'b0, pix.pix_up});
			dt_q   <= $signed({1'b0, pix.pix_now}) - $signed({1'b0, pix.pix_before});
			w_q    <= pix.weight[lkw_pkg::PIX_WEIGHT_W-1 -: WEIGHT_BITS];
			last_q <= pix.last;
		end
		pp_s1   <= pp_c;
		term_s2 <= $signed(lkw_pkg::SUM_W'(pw_c)) <<< WSH;
	end

endmodule

FILE: design/lkw_checker.sv
// Port-level checks for the window block, bound to the top level.
module lkw_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          pix_valid,
	input logic          pix_ready,
	input logic          res_valid,
	input logic          res_ready,
	input lkw_pkg::res_t res
);

	a_pix_gap: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && pix_ready |=> !pix_ready)
		else $error("pix_ready stayed high after a transaction");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result changed or dropped while stalled");

	a_still_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.status != lkw_pkg::ST_MOVING |->
			res.vel_x == '0 && res.vel_y == '0)
		else $error("nonzero direction on a still or singular window");

	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res.vel_x <= 16'sd16384 && res.vel_x >= -16'sd16384 &&
			res.vel_y <= 16'sd16384 && res.vel_y >= -16'sd16384)
		else $error("direction component outside unit range");

endmodule

bind weighted_lucas_kanade_window lkw_checker u_lkw_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.pix_valid (pix_valid),
	.pix_ready (pix_ready),
	.res_valid (res_valid),
	.res_ready (res_ready),
	.res       (res)
);

FILE: verif/weighted_lucas_kanade_window_chk.sv
// Flow checker: predicts each window result from accepted pixels and compares it.
module weighted_lucas_kanade_window_chk
	import lkw_pkg::*;
#(
	parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  pix_valid,
	input  logic                  pix_ready,
	input  pix_t                  pix,
	input  logic                  res_valid,
	input  logic                  res_ready,
	input  res_t                  res,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	input  logic                  pready,
	output int                    pending,
	output int                    errors
);

	logic signed [SUM_W-1:0] acc_xx, acc_yy, acc_xy, acc_xt, acc_yt;
	logic [DET_THR_W-1:0]    det_thr;
	logic [SPD_THR_W-1:0]    spd_thr;
	res_t                    flow_q[$];

	function automatic int bit_len(input logic [127:0] v);
		int n;
		n = 0;
		for (int i = 0; i < 128; i++)
			if (v[i])
				n = i + 1;
		return n;
	endfunction

	function automatic logic [63:0] int_sqrt(input logic [63:0] v);
		logic [63:0] r, t;
		r = 0;
		for (int i = 31; i >= 0; i--) begin
			t = r | (64'd1 << i);
			if (t * t <= v)
				r = t;
		end
		return r;
	endfunction

	function automatic logic [15:0] unit_comp(input logic [63:0] b, input logic [63:0] m,
			input bit neg);
		logic [63:0] mag;
		mag = (b * 64'd16384 + m / 2) / m;
		if (mag > 64'd16384)
			mag = 64'd16384;
		return neg ? 16'(-mag) : mag[15:0];
	endfunction

	// Solve the closed window's normal system into a direction result.
	function automatic res_t solve_flow(input logic signed [SUM_W-1:0] sxx,
			input logic signed [SUM_W-1:0] syy, input logic signed [SUM_W-1:0] sxy,
			input logic signed [SUM_W-1:0] sxt, input logic signed [SUM_W-1:0] syt);
		logic signed [127:0] xx, yy, xy, xt, yt, det, nv, nh;
		logic [127:0]        ad, av, ah, lhs, rhs;
		logic [63:0]         a0, a1, a2, m;
		int                  s;
		res_t                r;
		xx = sxx; yy = syy; xy = sxy; xt = sxt; yt = syt;
		r = '0;
		det = yy * xx - xy * xy;
		nv = yt * xx - xy * xt;
		nh = yy * xt - xy * yt;
		ad = det[127] ? -det : det;
		av = nv[127] ? -nv : nv;
		ah = nh[127] ? -nh : nh;
		if (!(ad > 128'(det_thr))) begin
			r.status = ST_SINGULAR;
			return r;
		end
		s = bit_len(av > ah ? av : ah);
		if (bit_len(ad) > s)
			s = bit_len(ad);
		s = s > 31 ? s - 31 : 0;
		a0 = 64'(av >> s); a1 = 64'(ah >> s); a2 = 64'(ad >> s);
		lhs = 128'(a0 * a0 + a1 * a1) * 128'd65536;
		rhs = 128'(64'(spd_thr) * 64'(spd_thr)) * 128'(a2 * a2);
		if (lhs == 0 || !(lhs > rhs)) begin
			r.status = ST_SLOW;
			return r;
		end
		s = bit_len(av > ah ? av : ah);
		s = s > 30 ? s - 30 : 0;
		a0 = 64'(av >> s); a1 = 64'(ah >> s);
		m = int_sqrt(a0 * a0 + a1 * a1);
		if (m == 0) begin
			r.status = ST_SLOW;
			return r;
		end
		r.vel_x = unit_comp(a1, m, nh[127] == det[127]);
		r.vel_y = unit_comp(a0, m, nv[127] == det[127]);
		r.status = ST_MOVING;
		return r;
	endfunction

	task automatic report(input string what, input int got, input int want);
		$display("mismatch on %s: got %0d, expected %0d", what, got, want);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		longint     dx, dy, dt, w;
		logic signed [SUM_W-1:0] nxx, nyy, nxy, nxt, nyt;
		res_t       want;
		if (!arst_n) begin
			acc_xx = 0; acc_yy = 0; acc_xy = 0; acc_xt = 0; acc_yt = 0;
			det_thr = DET_THR_RST;
			spd_thr = SPD_THR_RST;
			flow_q.delete();
			pending <= 0;
			errors = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[3] == REG_SPD_THR)
					spd_thr = pwdata[SPD_THR_W-1:0];
				else
					det_thr = pwdata[DET_THR_W-1:0];
			end
			if (res_valid && res_ready) begin
				if (flow_q.size() == 0) begin
					report("result transaction count", 1, 0);
				end else begin
					want = flow_q.pop_front();
					if (res.vel_x !== want.vel_x)
						report("vel_x", res.vel_x, want.vel_x);
					if (res.vel_y !== want.vel_y)
						report("vel_y", res.vel_y, want.vel_y);
					if (res.status !== want.status)
						report("status", res.status, want.status);
				end
			end
			if (pix_valid && pix_ready) begin
				dx = longint'(pix.pix_right) - longint'(pix.pix_left);
				dy = longint'(pix.pix_down) - longint'(pix.pix_up);
				dt = longint'(pix.pix_now) - longint'(pix.pix_before);
				w = longint'(pix.weight) & ~((64'd1 << (16 - WEIGHT_BITS)) - 1);
				nxx = acc_xx + SUM_W'(w * dx * dx);
				nyy = acc_yy + SUM_W'(w * dy * dy);
				nxy = acc_xy + SUM_W'(w * dx * dy);
				nxt = acc_xt + SUM_W'(w * dx * dt);
				nyt = acc_yt + SUM_W'(w * dy * dt);
				if (pix.last) begin
					flow_q = {flow_q, solve_flow(nxx, nyy, nxy, nxt, nyt)};
					acc_xx = 0; acc_yy = 0; acc_xy = 0; acc_xt = 0; acc_yt = 0;
				end else begin
					acc_xx = nxx; acc_yy = nyy; acc_xy = nxy; acc_xt = nxt; acc_yt = nyt;
				end
			end
			pending <= flow_q.size();
		end
	end

endmodule

FILE: verif/weighted_lucas_kanade_window_tb.sv
// Testbench top: pixel windows, threshold writes, stalls and the verdict.
module weighted_lucas_kanade_window_tb;
	import lkw_pkg::*;

	logic                  clk;
	logic                  arst_n;
	logic                  pix_valid;
	logic                  pix_ready;
	pix_t                  pix;
	logic                  res_valid;
	logic                  res_ready;
	res_t                  res;
	logic                  psel, penable, pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;
	int                    pending;
	int                    errors;
	int                    send_idle;
	int                    recv_idle;
	int                    hold_req;
	int                    hold_left;

	weighted_lucas_kanade_window u_top (
		.clk(clk), .arst_n(arst_n),
		.pix_valid(pix_valid), .pix_ready(pix_ready), .pix(pix),
		.res_valid(res_valid), .res_ready(res_ready), .res(res),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	weighted_lucas_kanade_window_chk u_chk (
		.clk(clk), .arst_n(arst_n),
		.pix_valid(pix_valid), .pix_ready(pix_ready), .pix(pix),
		.res_valid(res_valid), .res_ready(res_ready), .res(res),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready), .pending(pending), .errors(errors)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// Receiver: random stalls, plus a long hold-off when requested.
	always @(posedge clk) begin
		if (hold_req > 0 && hold_left == 0) begin
			hold_left <= hold_req;
			res_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			res_ready <= 1'b0;
		end else begin
			res_ready <= $urandom_range(99) >= recv_idle;
		end
	end

	initial begin
		#80000000;
		$display("Verification failed");
		$finish;
	end

	task automatic send_pix(input pix_t p);
		while ($urandom_range(99) < send_idle) begin
			pix_valid <= 1'b0;
			@(posedge clk);
		end
		pix <= p;
		pix_valid <= 1'b1;
		@(posedge clk);
		while (!pix_ready)
			@(posedge clk);
	endtask

	task automatic reg_write(input logic regsel, input logic [APB_DATA_W-1:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {regsel, 3'b000};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Drain all results, then let a solve with no result still pending finish.
	task automatic drain();
		pix_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (1200) @(posedge clk);
	endtask

	function automatic pix_t make_pix(input bit smooth, input bit last);
		pix_t p;
		int   base;
		p = pix_t'(65'({$urandom, $urandom, $urandom}));
		if (smooth) begin
			base = $urandom_range(40, 215);
			p.pix_left = 8'(base - int'($urandom_range(0, 30)));
			p.pix_right = 8'(base + int'($urandom_range(0, 30)));
			p.pix_up = 8'(base - int'($urandom_range(0, 30)));
			p.pix_down = 8'(base + int'($urandom_range(0, 30)));
			p.pix_now = 8'(base);
			p.pix_before = 8'(base + int'($urandom_range(0, 40)) - 20);
		end
		if ($urandom_range(19) == 0)
			p.weight = $urandom_range(1) ? 16'hffff : 16'h0000;
		p.last = last;
		return p;
	endfunction

	task automatic send_window(input int len, input bit smooth);
		for (int i = 0; i < len; i++)
			send_pix(make_pix(smooth, i == len - 1));
	endtask

	initial begin
		pix_t p;
		arst_n = 1'b0;
		pix_valid = 1'b0;
		pix = '0;
		res_ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		send_idle = 16;
		recv_idle = 64;
		hold_req = 0;
		hold_left = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: all-flat window (singular), lone last pixel, extreme values.
		p = '0;
		p.weight = 16'hffff;
		send_pix(p);
		p.last = 1'b1;
		send_pix(p);
		p = '{8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 16'hffff, 1'b1};
		send_pix(p);
		p = '{8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd255, 16'hffff, 1'b0};
		send_pix(p);
		p = '{8'd0, 8'd255, 8'd255, 8'd0, 8'd255, 8'd0, 16'hffff, 1'b0};
		send_pix(p);
		p = '{8'd128, 8'd0, 8'd0, 8'd0, 8'd77, 8'd0, 16'h0001, 1'b1};
		send_pix(p);
		// Zero weight leaves the sums empty.
		p = '{8'd200, 8'd10, 8'd90, 8'd3, 8'd60, 8'd1, 16'h0000, 1'b1};
		send_pix(p);
		send_window(4, 1'b1);
		send_window(6, 1'b1);
		send_window(5, 1'b0);
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			send_idle = ph < 2 ? 16 : (ph < 4 ? 64 : 0);
			recv_idle = ph < 2 ? 64 : (ph < 4 ? 16 : 0);
			case (ph)
				1: begin
					reg_write(REG_DET_THR, 64'd0);
					reg_write(REG_SPD_THR, 64'd0);
				end
				2: begin
					reg_write(REG_DET_THR, 64'hff_ffff_ffff);
					reg_write(REG_SPD_THR, 64'hffff);
				end
				3: begin
					reg_write(REG_DET_THR, {$urandom, $urandom} & 64'h3f_ffff);
					reg_write(REG_SPD_THR, 64'($urandom_range(1, 2000)));
				end
				4: begin
					reg_write(REG_DET_THR, {$urandom, $urandom});
					reg_write(REG_SPD_THR, {$urandom, $urandom});
				end
				5: begin
					reg_write(REG_DET_THR, 64'd1);
					reg_write(REG_SPD_THR, 64'($urandom_range(0, 300)));
				end
				default: ;
			endcase
			if (ph == 1)
				hold_req = 6000;
			for (int k = 0; k < 200; ) begin
				int len;
				len = $urandom_range(7) == 0 ? $urandom_range(20, 40) : $urandom_range(1, 8);
				send_window(len, $urandom_range(3) != 0);
				k += len;
				hold_req = 0;
			end
			// Overflowing window: many maximal-gradient pixels wrap the sums.
			if (ph == 4) begin
				p = '{8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 16'hffff, 1'b0};
				for (int i = 0; i < 700; i++) begin
					p.pix_down = $urandom_range(1) ? 8'd255 : 8'd0;
					p.pix_before = 8'($urandom_range(255));
					p.last = i == 699;
					send_pix(p);
				end
			end
			drain();
		end

		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
